@@ rtl/core/bpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buoyancy piston position controller package
// Request and result types, motor modes, register map and reset values.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int PRESSURE_W  = 20;
    localparam int POSITION_W  = 32;
    localparam int APB_ADDR_W  = 5;
    localparam int APB_DATA_W  = 32;

    typedef struct packed {
        logic                  cmd;
        logic [1:0]            phase;
        logic [PRESSURE_W-1:0] pressure;
        logic                  auto_switch;
        logic                  push_level;
        logic                  pull_level;
    } bpc_req_t;

    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_RISE = 2'd1,
        MODE_SINK = 2'd2
    } motor_mode_t;

    typedef struct packed {
        logic                         drive_update;
        logic [7:0]                   drive_a;
        logic [7:0]                   drive_b;
        motor_mode_t                  motor_mode;
        logic signed [POSITION_W-1:0] position_out;
        logic                         auto_active;
    } bpc_rsp_t;

    typedef enum logic [2:0] {
        REG_TARGET_PRESSURE  = 3'd0,
        REG_PRESSURE_BAND    = 3'd1,
        REG_START_PRESSURE   = 3'd2,
        REG_NEUTRAL_POSITION = 3'd3,
        REG_GRID_STEP        = 3'd4,
        REG_ARRIVE_WINDOW    = 3'd5,
        REG_SEEK_SPEED       = 3'd6,
        REG_MANUAL_SPEED     = 3'd7
    } cfg_reg_t;

    localparam logic CMD_ENCODER = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    localparam logic [7:0] STOP_DUTY = 8'd1;

    localparam logic [15:0] TARGET_PRESSURE_RST  = 16'd1055;
    localparam logic [7:0]  PRESSURE_BAND_RST    = 8'd5;
    localparam logic [15:0] START_PRESSURE_RST   = 16'd1023;
    localparam logic [7:0]  NEUTRAL_POSITION_RST = 8'd0;
    localparam logic [7:0]  GRID_STEP_RST        = 8'd0;
    localparam logic [7:0]  ARRIVE_WINDOW_RST    = 8'd3;
    localparam logic [7:0]  SEEK_SPEED_RST       = 8'd100;
    localparam logic [7:0]  MANUAL_SPEED_RST     = 8'd255;

    typedef logic signed [1:0] step_t;

    // Indexed by new phase, then previous phase.
    localparam step_t STEP_TABLE [0:3][0:3] = '{
        '{ 2'sd0, -2'sd1,  2'sd1,  2'sd0},
        '{ 2'sd1,  2'sd0,  2'sd0, -2'sd1},
        '{-2'sd1,  2'sd0,  2'sd0,  2'sd1},
        '{ 2'sd0,  2'sd1, -2'sd1,  2'sd0}
    };

endpackage

@@ rtl/core/buoyancy_piston_position_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Buoyancy piston position controller
// Quadrature encoder counter with a bang-bang piston position seeker and manual drive.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_ready   bpc_req_t
// rsp      out        rsp_valid / rsp_ready   bpc_rsp_t
// apb      in         psel / penable / pready register writes and reads
//
// One request is taken per cycle while the result is not stalled; an accepted
// request passes through the request register and then the result register.
// Reset clears the position, the phase, auto mode, the done flags and the
// registers to their default values.
// While rsp_ready is low the result holds and one more request is buffered.
// ----------------------------------------------------------------------------
module buoyancy_piston_position_controller #(
    parameter int PRESSURE_FRAC_BITS = 4
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             req_valid,
    output logic                                  req_ready,
    input  wire bpc_pkg::bpc_req_t                req,
    output logic                                  rsp_valid,
    input  wire logic                             rsp_ready,
    output bpc_pkg::bpc_rsp_t                     rsp,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bpc_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bpc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bpc_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);

    import bpc_pkg::*;

    localparam int HI_W = 17 + PRESSURE_FRAC_BITS;
    localparam int CW   = ((HI_W > PRESSURE_W) ? HI_W : PRESSURE_W) + 2;

    logic [15:0] target_pressure_reg;
    logic [7:0]  pressure_band_reg;
    logic [15:0] start_pressure_reg;
    logic [7:0]  neutral_position_reg;
    logic [7:0]  grid_step_reg;
    logic [7:0]  arrive_window_reg;
    logic [7:0]  seek_speed_reg;
    logic [7:0]  manual_speed_reg;

    logic                         req_valid_reg;
    logic                         req_valid_next;
    bpc_req_t                     req_data_reg;
    logic                         rsp_valid_reg;
    logic                         rsp_valid_next;
    bpc_rsp_t                     rsp_data_reg;
    bpc_rsp_t                     rsp_data_next;

    logic signed [POSITION_W-1:0] position_reg;
    logic signed [POSITION_W-1:0] position_next;
    logic [1:0]                   last_phase_reg;
    logic [1:0]                   last_phase_next;
    logic                         auto_mode_reg;
    logic                         auto_mode_next;
    logic                         rise_done_reg;
    logic                         rise_done_next;
    logic                         sink_done_reg;
    logic                         sink_done_next;
    logic                         neutral_done_reg;
    logic                         neutral_done_next;

    logic                         req_fire;
    logic                         stage_adv;
    logic                         cfg_write;
    cfg_reg_t                     cfg_sel;

    logic signed [CW-1:0]         pres_s;
    logic signed [CW-1:0]         hi_s;
    logic signed [CW-1:0]         lo_s;
    logic signed [CW-1:0]         start_s;
    logic [16:0]                  hi_sum;
    logic signed [17:0]           lo_diff;
    logic                         below_start;
    logic                         above_hi;
    logic                         below_lo;

    logic signed [9:0]            neutral_s;
    logic signed [9:0]            grid2_s;
    logic signed [9:0]            target_pos;
    logic                         band_done;
    logic signed [33:0]           pos_err;
    logic [33:0]                  pos_err_abs;
    logic                         arrived;
    step_t                        step;

    logic                         drv_upd;
    motor_mode_t                  drv_mode;
    logic [7:0]                   drv_speed;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_pressure_reg  <= TARGET_PRESSURE_RST;
            pressure_band_reg    <= PRESSURE_BAND_RST;
            start_pressure_reg   <= START_PRESSURE_RST;
            neutral_position_reg <= NEUTRAL_POSITION_RST;
            grid_step_reg        <= GRID_STEP_RST;
            arrive_window_reg    <= ARRIVE_WINDOW_RST;
            seek_speed_reg       <= SEEK_SPEED_RST;
            manual_speed_reg     <= MANUAL_SPEED_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_TARGET_PRESSURE:  target_pressure_reg  <= pwdata[15:0];
                REG_PRESSURE_BAND:    pressure_band_reg    <= pwdata[7:0];
                REG_START_PRESSURE:   start_pressure_reg   <= pwdata[15:0];
                REG_NEUTRAL_POSITION: neutral_position_reg <= pwdata[7:0];
                REG_GRID_STEP:        grid_step_reg        <= pwdata[7:0];
                REG_ARRIVE_WINDOW:    arrive_window_reg    <= pwdata[7:0];
                REG_SEEK_SPEED:       seek_speed_reg       <= pwdata[7:0];
                REG_MANUAL_SPEED:     manual_speed_reg     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_TARGET_PRESSURE:  prdata = {16'd0, target_pressure_reg};
            REG_PRESSURE_BAND:    prdata = {24'd0, pressure_band_reg};
            REG_START_PRESSURE:   prdata = {16'd0, start_pressure_reg};
            REG_NEUTRAL_POSITION: prdata = {24'd0, neutral_position_reg};
            REG_GRID_STEP:        prdata = {24'd0, grid_step_reg};
            REG_ARRIVE_WINDOW:    prdata = {24'd0, arrive_window_reg};
            REG_SEEK_SPEED:       prdata = {24'd0, seek_speed_reg};
            REG_MANUAL_SPEED:     prdata = {24'd0, manual_speed_reg};
            default:              prdata = '0;
        endcase
    end

    assign stage_adv = req_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !req_valid_reg || stage_adv;
    assign req_fire  = req_valid && req_ready;

    assign req_valid_next = req_fire ? 1'b1 : (stage_adv ? 1'b0 : req_valid_reg);
    assign rsp_valid_next = stage_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_data_reg;

    assign pres_s  = $signed({{(CW-PRESSURE_W){1'b0}}, req_data_reg.pressure});
    assign hi_sum  = {1'b0, target_pressure_reg} + {9'd0, pressure_band_reg};
    assign lo_diff = $signed({2'b00, target_pressure_reg}) - $signed({10'd0, pressure_band_reg});
    assign hi_s    = $signed({{(CW-17){1'b0}}, hi_sum}) <<< PRESSURE_FRAC_BITS;
    assign lo_s    = $signed({{(CW-18){lo_diff[17]}}, lo_diff}) <<< PRESSURE_FRAC_BITS;
    assign start_s = $signed({{(CW-16){1'b0}}, start_pressure_reg}) <<< PRESSURE_FRAC_BITS;

    assign below_start = pres_s < start_s;
    assign above_hi    = pres_s > hi_s;
    assign below_lo    = pres_s < lo_s;

    assign neutral_s = $signed({{2{neutral_position_reg[7]}}, neutral_position_reg});
    assign grid2_s   = $signed({grid_step_reg[7], grid_step_reg, 1'b0});

    always_comb
    begin
        if (above_hi)
        begin
            target_pos = neutral_s - grid2_s;
            band_done  = rise_done_reg;
        end
        else if (below_lo)
        begin
            target_pos = neutral_s + grid2_s;
            band_done  = sink_done_reg;
        end
        else
        begin
            target_pos = neutral_s;
            band_done  = neutral_done_reg;
        end
    end

    assign pos_err     = $signed({{24{target_pos[9]}}, target_pos})
                       - $signed({{2{position_reg[POSITION_W-1]}}, position_reg});
    assign pos_err_abs = pos_err[33] ? 34'(-pos_err) : 34'(pos_err);
    assign arrived     = pos_err_abs <= {26'd0, arrive_window_reg};
    assign step        = STEP_TABLE[req_data_reg.phase][last_phase_reg];

    always_comb
    begin
        position_next     = position_reg;
        last_phase_next   = last_phase_reg;
        auto_mode_next    = auto_mode_reg;
        rise_done_next    = rise_done_reg;
        sink_done_next    = sink_done_reg;
        neutral_done_next = neutral_done_reg;
        drv_upd           = 1'b0;
        drv_mode          = MODE_STOP;
        drv_speed         = 8'd0;

        case (req_data_reg.cmd)
            CMD_ENCODER:
            begin
                position_next   = position_reg + $signed({{(POSITION_W-2){step[1]}}, step});
                last_phase_next = req_data_reg.phase;
            end
            CMD_TICK:
            begin
                if (!auto_mode_reg)
                begin
                    if (req_data_reg.auto_switch)
                    begin
                        auto_mode_next = 1'b1;
                    end
                    else if (req_data_reg.push_level && !req_data_reg.pull_level)
                    begin
                        drv_upd   = 1'b1;
                        drv_mode  = MODE_SINK;
                        drv_speed = manual_speed_reg;
                    end
                    else if (req_data_reg.pull_level && !req_data_reg.push_level)
                    begin
                        drv_upd   = 1'b1;
                        drv_mode  = MODE_RISE;
                        drv_speed = manual_speed_reg;
                    end
                    else
                    begin
                        drv_upd = 1'b1;
                    end
                end
                else if (below_start)
                begin
                    drv_upd = 1'b1;
                end
                else if (!band_done)
                begin
                    drv_upd   = 1'b1;
                    drv_speed = seek_speed_reg;
                    if (arrived)
                    begin
                        drv_mode = MODE_STOP;
                        if (above_hi)
                        begin
                            rise_done_next = 1'b1;
                        end
                        else if (below_lo)
                        begin
                            sink_done_next = 1'b1;
                        end
                        else
                        begin
                            neutral_done_next = 1'b1;
                        end
                    end
                    else if (pos_err[33])
                    begin
                        drv_mode = MODE_RISE;
                    end
                    else
                    begin
                        drv_mode = MODE_SINK;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        rsp_data_next              = '0;
        rsp_data_next.drive_update = drv_upd;
        rsp_data_next.motor_mode   = MODE_STOP;
        rsp_data_next.position_out = position_next;
        rsp_data_next.auto_active  = auto_mode_next;
        if (drv_upd)
        begin
            rsp_data_next.motor_mode = drv_mode;
            case (drv_mode)
                MODE_RISE:
                begin
                    rsp_data_next.drive_a = 8'd0;
                    rsp_data_next.drive_b = drv_speed;
                end
                MODE_SINK:
                begin
                    rsp_data_next.drive_a = drv_speed;
                    rsp_data_next.drive_b = 8'd0;
                end
                default:
                begin
                    rsp_data_next.drive_a = STOP_DUTY;
                    rsp_data_next.drive_b = STOP_DUTY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg    <= 1'b0;
            rsp_valid_reg    <= 1'b0;
            position_reg     <= '0;
            last_phase_reg   <= 2'd0;
            auto_mode_reg    <= 1'b0;
            rise_done_reg    <= 1'b0;
            sink_done_reg    <= 1'b0;
            neutral_done_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (stage_adv)
            begin
                position_reg     <= position_next;
                last_phase_reg   <= last_phase_next;
                auto_mode_reg    <= auto_mode_next;
                rise_done_reg    <= rise_done_next;
                sink_done_reg    <= sink_done_next;
                neutral_done_reg <= neutral_done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            req_data_reg <= req;
        end
        if (stage_adv)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

`ifndef ASSERT_OFF
    a_auto_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        auto_mode_reg |=> auto_mode_reg)
        else $error("auto mode dropped back to manual");

    a_done_needs_auto: assert property (@(posedge clk) disable iff (!rst_n)
        (rise_done_reg || sink_done_reg || neutral_done_reg) |-> auto_mode_reg)
        else $error("band done flag set outside auto mode");

    a_idle_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_data_reg.drive_update) |->
        (rsp_data_reg.drive_a == 8'd0 && rsp_data_reg.drive_b == 8'd0
         && rsp_data_reg.motor_mode == MODE_STOP))
        else $error("drive fields set on a result without a drive update");

    a_done_with_stop: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(rise_done_reg) || $rose(sink_done_reg) || $rose(neutral_done_reg)) |->
        (rsp_valid_reg && rsp_data_reg.drive_update
         && rsp_data_reg.motor_mode == MODE_STOP))
        else $error("band done flag latched without a stop result");

    a_result_auto_state: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (rsp_data_reg.auto_active == auto_mode_reg))
        else $error("result auto flag disagrees with the mode state");
`endif

endmodule
`default_nettype wire
